>>> rtl/pfls_pkg.sv
// Package with shared types and constants for the per-flow latency statistics block.
`timescale 1ns / 1ps
package pfls_pkg;
    localparam int unsigned IdW    = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned MeanW  = 40;
    localparam int unsigned CountW = 32;
    localparam int unsigned StatW  = 2;
    localparam int unsigned SlotW  = 4;
    localparam int unsigned CfgW   = 5;

    localparam logic [StatW-1:0] ST_EXISTING = 2'd0;
    localparam logic [StatW-1:0] ST_NEW      = 2'd1;
    localparam logic [StatW-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [IdW-1:0]   sender_id;
        logic [TimeW-1:0] send_time;
        logic [TimeW-1:0] arrival_time;
    } t_req;

    typedef struct packed {
        logic [StatW-1:0]  status;
        logic [SlotW-1:0]  slot;
        logic [TimeW-1:0]  packet_delay;
        logic [MeanW-1:0]  sender_mean;
        logic [CountW-1:0] sender_count;
        logic [MeanW-1:0]  overall_mean;
        logic [CountW-1:0] overall_count;
    } t_rsp;
endpackage

>>> rtl/pfls_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface pfls_req_if;
    logic          valid;
    logic          ready;
    pfls_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pfls_rsp_if;
    logic          valid;
    logic          ready;
    pfls_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pfls_div.sv
// Bit-serial unsigned divider of a 72-bit dividend by a 33-bit divisor, 40-bit quotient.
`timescale 1ns / 1ps
module pfls_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [71:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [39:0] o_quot
);
    logic [71:0] r_num, n_num;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_sh;

    always_comb begin
        w_sh = {r_rem[32:0], r_num[71]};
        n_num = {r_num[70:0], 1'b0};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_num[0] = 1'b1;
        end else begin
            n_rem = w_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd72;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_num[39:0];
endmodule

>>> rtl/pfls_front.sv
// Front end: takes requests, computes the delay and queues them in a two-entry FIFO.
`timescale 1ns / 1ps
module pfls_front (
    input  logic i_clk,
    input  logic i_rst_n,
    pfls_req_if.sink in_req,
    output logic                       o_valid,
    output pfls_pkg::t_req             o_req,
    output logic [pfls_pkg::TimeW-1:0] o_delay,
    input  logic                       i_take
);
    pfls_pkg::t_req r_q [2];
    logic [pfls_pkg::TimeW-1:0] r_d [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign in_req.ready = (r_cnt != 2'd2);
    assign w_push = in_req.valid && in_req.ready;
    assign w_pop  = i_take && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req = r_q[r_rp];
    assign o_delay = r_d[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= in_req.payload;
                r_d[r_wp] <= in_req.payload.arrival_time - in_req.payload.send_time;
                r_wp <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> rtl/pfls_back.sv
// Back end: sender table search, mean updates through a serial divider, result register.
`timescale 1ns / 1ps
module pfls_back #(
    parameter int MAX_SENDERS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [pfls_pkg::CfgW-1:0]  i_limit,
    input  logic                       i_valid,
    input  pfls_pkg::t_req             i_req,
    input  logic [pfls_pkg::TimeW-1:0] i_delay,
    output logic                       o_take,
    pfls_rsp_if.source out_rsp
);
    localparam int IW = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
    localparam int CW = $clog2(MAX_SENDERS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_DTOT = 6'b000100,
        S_DSLT = 6'b001000, S_DONE = 6'b010000, S_OUT  = 6'b100000
    } t_state;

    t_state r_st;
    logic [MAX_SENDERS-1:0] r_vld;
    logic [pfls_pkg::IdW-1:0]    r_sid   [MAX_SENDERS];
    logic [pfls_pkg::CountW-1:0] r_scnt  [MAX_SENDERS];
    logic [pfls_pkg::MeanW-1:0]  r_smean [MAX_SENDERS];
    logic [pfls_pkg::CountW-1:0] r_tcnt;
    logic [pfls_pkg::MeanW-1:0]  r_tmean;
    logic [CW-1:0] r_i, w_lim;
    logic [IW-1:0] r_s;
    pfls_pkg::t_req r_req;
    logic [pfls_pkg::TimeW-1:0] r_dly;
    pfls_pkg::t_rsp r_rsp;
    pfls_pkg::t_rsp r_obuf;
    logic r_ovld;
    logic w_load;

    logic        r_dstart;
    logic [71:0] r_num;
    logic [32:0] r_den;
    logic        w_ddone;
    logic [39:0] w_quot;
    logic [pfls_pkg::MeanW-1:0] w_dq;
    logic [IW-1:0] w_i;

    pfls_div u_div (.i_clk, .i_rst_n, .i_start(r_dstart), .i_num(r_num), .i_den(r_den),
                    .o_done(w_ddone), .o_quot(w_quot));

    assign w_lim = ({{(32-pfls_pkg::CfgW){1'b0}}, i_limit} > 32'(MAX_SENDERS)) ?
                   CW'(MAX_SENDERS) : CW'(i_limit);
    assign w_dq = {r_dly, 8'd0};
    assign w_i = r_i[IW-1:0];
    assign o_take = (r_st == S_IDLE) && i_valid;
    assign w_load = (r_st == S_OUT) && (!r_ovld || out_rsp.ready);
    assign out_rsp.valid = r_ovld;
    assign out_rsp.payload = r_obuf;

    function automatic logic [31:0] f_inc(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // The new mean is the old one moved by the distance to the new sample divided by n + 1;
    // a downward move is rounded up so that the result equals the truncated quotient.
    function automatic logic [71:0] f_num(input logic [39:0] m, input logic [39:0] dq,
                                          input logic [31:0] n);
        if (dq >= m) return {32'd0, dq - m};
        else return {31'd0, {1'b0, m - dq} + {9'd0, n}};
    endfunction

    function automatic logic [39:0] f_apply(input logic [39:0] m, input logic [39:0] dq,
                                            input logic [39:0] q);
        return (dq >= m) ? m + q : m - q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_vld    <= '0;
            r_tcnt   <= '0;
            r_tmean  <= '0;
            r_ovld   <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (w_load) r_ovld <= 1'b1;
            else if (out_rsp.ready) r_ovld <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req;
                        r_dly <= i_delay;
                        r_i   <= '0;
                        r_st  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_i >= w_lim) begin
                        r_rsp <= '{status: pfls_pkg::ST_FULL, slot: '0, packet_delay: r_dly,
                                   sender_mean: '0, sender_count: '0,
                                   overall_mean: r_tmean, overall_count: r_tcnt};
                        r_st <= S_OUT;
                    end else if (!r_vld[w_i] || r_sid[w_i] == r_req.sender_id) begin
                        r_s <= w_i;
                        r_rsp.status <= r_vld[w_i] ? pfls_pkg::ST_EXISTING : pfls_pkg::ST_NEW;
                        r_rsp.slot <= pfls_pkg::SlotW'({{(32-IW){1'b0}}, w_i});
                        r_rsp.packet_delay <= r_dly;
                        if (r_tcnt == '0) begin
                            r_tmean <= w_dq;
                            r_tcnt  <= 32'd1;
                            r_st    <= S_DSLT;
                        end else begin
                            r_num    <= f_num(r_tmean, w_dq, r_tcnt);
                            r_den    <= {1'b0, r_tcnt} + 33'd1;
                            r_dstart <= 1'b1;
                            r_st     <= S_DTOT;
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_DTOT: begin
                    if (w_ddone) begin
                        r_tmean <= f_apply(r_tmean, w_dq, w_quot);
                        r_tcnt  <= f_inc(r_tcnt);
                        r_st    <= S_DSLT;
                    end
                end
                S_DSLT: begin
                    if (r_rsp.status == pfls_pkg::ST_NEW) begin
                        r_vld[r_s]   <= 1'b1;
                        r_sid[r_s]   <= r_req.sender_id;
                        r_smean[r_s] <= w_dq;
                        r_scnt[r_s]  <= 32'd1;
                        r_st <= S_DONE;
                    end else begin
                        r_num    <= f_num(r_smean[r_s], w_dq, r_scnt[r_s]);
                        r_den    <= {1'b0, r_scnt[r_s]} + 33'd1;
                        r_dstart <= 1'b1;
                        r_st     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (r_rsp.status == pfls_pkg::ST_NEW) begin
                        r_rsp.sender_mean  <= r_smean[r_s];
                        r_rsp.sender_count <= r_scnt[r_s];
                        r_rsp.overall_mean <= r_tmean;
                        r_rsp.overall_count <= r_tcnt;
                        r_st <= S_OUT;
                    end else if (w_ddone) begin
                        r_smean[r_s] <= f_apply(r_smean[r_s], w_dq, w_quot);
                        r_scnt[r_s]  <= f_inc(r_scnt[r_s]);
                        r_rsp.sender_mean  <= f_apply(r_smean[r_s], w_dq, w_quot);
                        r_rsp.sender_count <= f_inc(r_scnt[r_s]);
                        r_rsp.overall_mean <= r_tmean;
                        r_rsp.overall_count <= r_tcnt;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_obuf <= r_rsp;
                        r_st   <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/per_flow_latency_stats.sv
// Top level of the per-flow latency statistics block.
//   channel   dir  contents
//   in_req    in   sender_id, send_time, arrival_time
//   out_rsp   out  status, slot, delay, sender and overall means and counts
//   cfg       in   senders_in_use, one write per enable
// An item holds the back end through the table scan, up to two serial divisions for the
// overall and the sender mean, and the remaining state steps.
// Reset clears the table valid bits, the totals and sets senders_in_use to 16.
// A two-entry request queue keeps accepting, until it is full, while the back end works or stalls.
// A result waiting in the output register holds the back end in its output state.
`timescale 1ns / 1ps
module per_flow_latency_stats #(
    parameter int MAX_SENDERS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    pfls_req_if.sink   in_req,
    pfls_rsp_if.source out_rsp
);
    logic [pfls_pkg::CfgW-1:0] r_lim;
    logic w_valid, w_take;
    pfls_pkg::t_req w_req;
    logic [pfls_pkg::TimeW-1:0] w_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lim <= 5'd16;
        else if (i_cfg_we) r_lim <= i_cfg_data;
    end

    pfls_front u_front (.i_clk, .i_rst_n, .in_req, .o_valid(w_valid), .o_req(w_req),
                        .o_delay(w_delay), .i_take(w_take));

    pfls_back #(.MAX_SENDERS(MAX_SENDERS)) u_back (.i_clk, .i_rst_n, .i_limit(r_lim),
        .i_valid(w_valid), .i_req(w_req), .i_delay(w_delay), .o_take(w_take), .out_rsp);
endmodule

>>> rtl/pfls_checker.sv
// Port-level assertions for the per-flow latency statistics block.
`timescale 1ns / 1ps
module pfls_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic out_valid,
    input logic out_ready,
    input pfls_pkg::t_rsp out_payload
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("rsp dropped");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_payload.status == pfls_pkg::ST_EXISTING ||
                       out_payload.status == pfls_pkg::ST_NEW ||
                       out_payload.status == pfls_pkg::ST_FULL)) else $error("bad status");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_payload.status == pfls_pkg::ST_FULL |->
        out_payload.sender_count == '0) else $error("full with count");
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_payload.status == pfls_pkg::ST_NEW |->
        out_payload.sender_count == 32'd1 && out_payload.overall_count != '0)
        else $error("new slot count");
endmodule

bind per_flow_latency_stats pfls_checker u_chk (.i_clk, .i_rst_n,
    .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_payload(out_rsp.payload));

>>> test/testbench.sv
// Self-checking testbench for the per-flow latency statistics block, with its own predictor.
`timescale 1ns / 1ps
module testbench;
    localparam int Slots = 16;
    localparam int CycleLimit = 2000000;
    localparam int SettleCycles = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pfls_pkg::CfgW-1:0] i_cfg_data = '0;

    pfls_req_if in_req ();
    pfls_rsp_if out_rsp ();

    per_flow_latency_stats #(.MAX_SENDERS(Slots)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .in_req(in_req.sink),
        .out_rsp(out_rsp.source)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        in_req.valid = 1'b0;
        in_req.payload = '0;
        out_rsp.ready = 1'b0;
    end

    // Shadow state of the sender table and totals.
    logic [pfls_pkg::CfgW-1:0] search_cfg = 5'd16;
    logic [Slots-1:0] tbl_valid = '0;
    logic [pfls_pkg::IdW-1:0] tbl_sender [Slots];
    logic [pfls_pkg::CountW-1:0] tbl_count [Slots];
    logic [pfls_pkg::MeanW-1:0] tbl_mean [Slots];
    logic [pfls_pkg::CountW-1:0] all_count = '0;
    logic [pfls_pkg::MeanW-1:0] all_mean = '0;

    pfls_pkg::t_req pending_packets [$];
    pfls_pkg::t_rsp expected_stats [$];
    logic [pfls_pkg::IdW-1:0] id_pool [24];
    bit idle_enable = 1'b1;
    int errors = 0;
    int results_seen = 0;
    int status_seen [3] = '{0, 0, 0};
    int cycles = 0;

    function automatic logic [pfls_pkg::MeanW-1:0] next_mean(
            logic [pfls_pkg::MeanW-1:0] m, logic [pfls_pkg::CountW-1:0] n,
            logic [pfls_pkg::MeanW-1:0] dq);
        logic [127:0] num;
        num = 128'(m) * 128'(n) + 128'(dq);
        return pfls_pkg::MeanW'(num / (128'(n) + 128'd1));
    endfunction

    function automatic logic [pfls_pkg::CountW-1:0] sat_inc(logic [pfls_pkg::CountW-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    task automatic account_packet(pfls_pkg::t_req p);
        pfls_pkg::t_rsp r;
        logic [pfls_pkg::MeanW-1:0] dq;
        int lim;
        int s;
        logic [pfls_pkg::StatW-1:0] st;
        r = '0;
        r.packet_delay = p.arrival_time - p.send_time;
        dq = {8'd0, r.packet_delay} << 8;
        lim = (search_cfg > Slots) ? Slots : int'(search_cfg);
        st = pfls_pkg::ST_FULL;
        s = 0;
        for (int i = 0; i < lim; i++) begin
            if (tbl_valid[i] && tbl_sender[i] == p.sender_id) begin
                st = pfls_pkg::ST_EXISTING;
                s = i;
                break;
            end
            if (!tbl_valid[i]) begin
                st = pfls_pkg::ST_NEW;
                s = i;
                break;
            end
        end
        r.status = st;
        if (st != pfls_pkg::ST_FULL) begin
            all_mean = (all_count == 0) ? dq : next_mean(all_mean, all_count, dq);
            all_count = sat_inc(all_count);
            if (st == pfls_pkg::ST_NEW) begin
                tbl_valid[s] = 1'b1;
                tbl_sender[s] = p.sender_id;
                tbl_mean[s] = dq;
                tbl_count[s] = 32'd1;
            end else begin
                tbl_mean[s] = next_mean(tbl_mean[s], tbl_count[s], dq);
                tbl_count[s] = sat_inc(tbl_count[s]);
            end
            r.slot = pfls_pkg::SlotW'(s);
            r.sender_mean = tbl_mean[s];
            r.sender_count = tbl_count[s];
        end
        r.overall_mean = all_mean;
        r.overall_count = all_count;
        expected_stats.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_req.valid <= 1'b0;
        end else begin
            if (in_req.valid && in_req.ready) begin
                account_packet(in_req.payload);
            end
            if (!in_req.valid || in_req.ready) begin
                if (pending_packets.size() > 0 && !(idle_enable && $urandom_range(99) < 21)) begin
                    in_req.valid <= 1'b1;
                    in_req.payload <= pending_packets.pop_front();
                end else begin
                    in_req.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        pfls_pkg::t_rsp want;
        pfls_pkg::t_rsp got;
        if (!i_rst_n) begin
            out_rsp.ready <= 1'b0;
        end else begin
            if (out_rsp.valid && out_rsp.ready) begin
                got = out_rsp.payload;
                results_seen++;
                if (expected_stats.size() == 0) begin
                    report_mismatch("unexpected result", 64'(got.status), 64'd0);
                end else begin
                    want = expected_stats.pop_front();
                    if (got.status < 3) status_seen[got.status]++;
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.slot !== want.slot)
                        report_mismatch("slot", 64'(got.slot), 64'(want.slot));
                    if (got.packet_delay !== want.packet_delay)
                        report_mismatch("packet_delay", 64'(got.packet_delay),
                                        64'(want.packet_delay));
                    if (got.sender_mean !== want.sender_mean)
                        report_mismatch("sender_mean", 64'(got.sender_mean),
                                        64'(want.sender_mean));
                    if (got.sender_count !== want.sender_count)
                        report_mismatch("sender_count", 64'(got.sender_count),
                                        64'(want.sender_count));
                    if (got.overall_mean !== want.overall_mean)
                        report_mismatch("overall_mean", 64'(got.overall_mean),
                                        64'(want.overall_mean));
                    if (got.overall_count !== want.overall_count)
                        report_mismatch("overall_count", 64'(got.overall_count),
                                        64'(want.overall_count));
                end
            end
            out_rsp.ready <= !(idle_enable && $urandom_range(99) < 21);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL per_flow_latency_stats");
            $finish;
        end
    end

    task automatic push_packet(logic [pfls_pkg::IdW-1:0] id, logic [pfls_pkg::TimeW-1:0] sent,
                               logic [pfls_pkg::TimeW-1:0] arrived);
        pfls_pkg::t_req p;
        p.sender_id = id;
        p.send_time = sent;
        p.arrival_time = arrived;
        pending_packets.push_back(p);
    endtask

    task automatic drain_and_settle();
        do @(posedge i_clk);
        while (pending_packets.size() > 0 || in_req.valid || expected_stats.size() > 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_search_range(logic [pfls_pkg::CfgW-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        search_cfg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_packets(int n);
        logic [pfls_pkg::IdW-1:0] id;
        logic [pfls_pkg::TimeW-1:0] sent;
        logic [pfls_pkg::TimeW-1:0] arrived;
        for (int k = 0; k < n; k++) begin
            id = ($urandom_range(99) < 75) ? id_pool[$urandom_range(23)] :
                 pfls_pkg::IdW'($urandom);
            sent = $urandom;
            case ($urandom_range(3))
                0: arrived = $urandom;
                1: arrived = sent + $urandom_range(255);
                default: arrived = sent + $urandom_range(100000);
            endcase
            push_packet(id, sent, arrived);
        end
    endtask

    initial begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < 24; i++) id_pool[i] = pfls_pkg::IdW'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_search_range(5'd16);
        push_packet(id_pool[0], 32'd0, 32'hFFFF_FFFF);
        push_packet(id_pool[0], 32'hFFFF_FFFF, 32'd0);
        push_packet(id_pool[1], 32'h1234_5678, 32'h1234_5678);
        push_packet(id_pool[1], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_packet(id_pool[0], 32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 2; i < 17; i++) push_packet(id_pool[i], 32'd100, 32'd100 + i);
        push_packet(id_pool[1], 32'd5, 32'd10);
        push_packet(id_pool[20], 32'd0, 32'hFFFF_FFFF);
        drain_and_settle();

        set_search_range(5'd0);
        random_packets(5);
        drain_and_settle();

        idle_enable = 1'b0;
        set_search_range(5'd31);
        random_packets(90);
        drain_and_settle();
        idle_enable = 1'b1;

        set_search_range(5'd3);
        random_packets(80);
        drain_and_settle();
        set_search_range(5'd1);
        random_packets(60);
        drain_and_settle();
        set_search_range(5'd17);
        random_packets(80);
        drain_and_settle();
        set_search_range(5'd8);
        random_packets(60);
        drain_and_settle();
        set_search_range(5'd16);
        random_packets(80);
        drain_and_settle();

        $display("Checked %0d results over search ranges 16, 0, 31, 3, 1, 17, 8 and 16.",
                 results_seen);
        $display("Existing sender %0d, new slot %0d, table full %0d.",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (errors == 0 && expected_stats.size() == 0) begin
            $display("PASS per_flow_latency_stats");
        end else begin
            $display("FAIL per_flow_latency_stats");
        end
        $finish;
    end
endmodule
